[sv/cps_pkg.sv]
`timescale 1ns / 1ps

package cps_pkg;

    localparam int IDX_W      = 6;
    localparam int WORD_W     = 31;
    localparam int VAL_W      = 4;
    localparam int SUIT_W     = 2;
    localparam int SUIT_CARDS = 13;
    localparam int MOD_REM_W  = IDX_W + 1;
    localparam int MOD_CNT_W  = 5;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_J,
        ST_WR_R,
        ST_WR_J,
        ST_RD_0,
        ST_EMIT_0
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [SUIT_W-1:0] suit;
    } t_card;

    // Splits a card code into suit and rank, with the rank starting at one.
    function automatic t_card card_decode(input logic [IDX_W-1:0] code);
        t_card            card;
        logic [IDX_W-1:0] rank;
        rank = '0;
        card = '0;
        if (code < IDX_W'(SUIT_CARDS)) begin
            card.suit = SUIT_W'(0);
            rank      = code + IDX_W'(1);
        end else if (code < IDX_W'(2 * SUIT_CARDS)) begin
            card.suit = SUIT_W'(1);
            rank      = code - IDX_W'(SUIT_CARDS - 1);
        end else if (code < IDX_W'(3 * SUIT_CARDS)) begin
            card.suit = SUIT_W'(2);
            rank      = code - IDX_W'(2 * SUIT_CARDS - 1);
        end else if (code < IDX_W'(4 * SUIT_CARDS)) begin
            card.suit = SUIT_W'(3);
            rank      = code - IDX_W'(3 * SUIT_CARDS - 1);
        end else begin
            card.suit = SUIT_W'(0);
            rank      = code - IDX_W'(4 * SUIT_CARDS - 1);
        end
        card.value = rank[VAL_W-1:0];
        return card;
    endfunction

endpackage

[sv/cps_mod_unit.sv]
`timescale 1ns / 1ps

module cps_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cps_pkg::WORD_W-1:0]  i_dividend,
    input  logic [cps_pkg::IDX_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [cps_pkg::IDX_W-1:0]   o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [cps_pkg::MOD_CNT_W-1:0]  r_count;
    logic [cps_pkg::WORD_W-1:0]     r_dividend;
    logic [cps_pkg::IDX_W-1:0]      r_divisor;
    logic [cps_pkg::MOD_REM_W-1:0]  r_rem;
    logic [cps_pkg::MOD_REM_W-1:0]  shifted;
    logic [cps_pkg::MOD_REM_W-1:0]  n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem[cps_pkg::IDX_W-1:0], r_dividend[cps_pkg::WORD_W-1]};
        if (shifted >= {1'b0, r_divisor}) begin
            n_rem = shifted - {1'b0, r_divisor};
        end else begin
            n_rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_count == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
            r_count    <= cps_pkg::MOD_CNT_W'(cps_pkg::WORD_W - 1);
        end else if (r_busy) begin
            r_dividend <= {r_dividend[cps_pkg::WORD_W-2:0], 1'b0};
            r_rem      <= n_rem;
            r_count    <= r_count - cps_pkg::MOD_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[cps_pkg::IDX_W-1:0];

endmodule

[sv/card_permutation_shuffler_top.sv]
`timescale 1ns / 1ps

// Fisher-Yates deck shuffler. Pulse start while busy is low; a rebuild word
// restores the ordered deck in that same cycle and leaves busy low. A step
// word holds busy high until the step is done, so no new step is taken
// before the last one is through. The bit-serial remainder unit folds the
// random word into 0..r, one word bit per cycle, then hands the remainder
// over while entry r is read; entry j is read next, and entry r and then
// entry j are written back. The step that finishes the deck adds a read of
// position 0. Each card comes out on o_strobe for exactly one cycle and
// must be taken then, since the receiver cannot stall the block. A step
// word after the deck is finished is dropped.
module card_permutation_shuffler_top #(
    parameter int DECK_SIZE = 52
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [cps_pkg::WORD_W-1:0]   i_random_word,
    output logic                         o_strobe,
    output logic [cps_pkg::IDX_W-1:0]    o_position,
    output logic [cps_pkg::VAL_W-1:0]    o_card_value,
    output logic [cps_pkg::SUIT_W-1:0]   o_card_suit,
    output logic                         o_last
);

    localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;

    cps_pkg::t_state r_state, n_state;

    logic [cps_pkg::IDX_W-1:0]  r_remaining, n_remaining;
    logic [cps_pkg::IDX_W-1:0]  r_j;
    logic [cps_pkg::IDX_W-1:0]  r_held;
    logic                       accept;
    logic                       mod_start;
    logic                       mod_done;
    logic [cps_pkg::IDX_W-1:0]  mod_rem;

    // Deck memory with a valid bit per entry; an unwritten entry holds its own index.
    logic [cps_pkg::IDX_W-1:0]  mem [DECK_SIZE];
    logic [DECK_SIZE-1:0]       r_valid;
    logic [cps_pkg::IDX_W-1:0]  r_rd_data;
    logic                       r_rd_valid;
    logic [AW-1:0]              r_rd_addr;
    logic [cps_pkg::IDX_W-1:0]  rd_value;
    logic [AW-1:0]              rd_addr;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [cps_pkg::IDX_W-1:0]  mem_wd;
    logic                       rebuild;

    logic                       n_strobe;
    logic [cps_pkg::IDX_W-1:0]  n_position;
    logic                       n_last;
    cps_pkg::t_card             n_card;

    logic                       r_strobe;
    logic [cps_pkg::IDX_W-1:0]  r_position;
    logic                       r_last;
    cps_pkg::t_card             r_card;

    assign accept = start && (r_state == cps_pkg::ST_IDLE);
    assign busy   = (r_state != cps_pkg::ST_IDLE);

    cps_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_random_word),
        .i_divisor  (r_remaining + cps_pkg::IDX_W'(1)),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign rd_value = r_rd_valid ? r_rd_data : cps_pkg::IDX_W'(r_rd_addr);

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        mod_start   = 1'b0;
        rebuild     = 1'b0;
        rd_addr     = r_remaining[AW-1:0];
        mem_we      = 1'b0;
        mem_wa      = r_remaining[AW-1:0];
        mem_wd      = rd_value;
        n_strobe    = 1'b0;
        n_position  = r_remaining;
        n_last      = 1'b0;
        n_card      = cps_pkg::card_decode(rd_value);
        unique case (r_state)
            cps_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == cps_pkg::REQ_BUILD) begin
                        rebuild     = 1'b1;
                        n_remaining = cps_pkg::IDX_W'(DECK_SIZE - 1);
                    end else if (r_remaining != '0 &&
                                 r_remaining < cps_pkg::IDX_W'(DECK_SIZE)) begin
                        mod_start = 1'b1;
                        n_state   = cps_pkg::ST_DIV;
                    end
                end
            end
            cps_pkg::ST_DIV: begin
                // The read of entry r is issued as the remainder comes out.
                if (mod_done) begin
                    n_state = cps_pkg::ST_RD_J;
                end
            end
            cps_pkg::ST_RD_J: begin
                rd_addr = r_j[AW-1:0];
                n_state = cps_pkg::ST_WR_R;
            end
            cps_pkg::ST_WR_R: begin
                mem_we   = 1'b1;
                mem_wa   = r_remaining[AW-1:0];
                mem_wd   = rd_value;
                n_strobe = 1'b1;
                n_state  = cps_pkg::ST_WR_J;
            end
            cps_pkg::ST_WR_J: begin
                mem_we      = 1'b1;
                mem_wa      = r_j[AW-1:0];
                mem_wd      = r_held;
                n_remaining = r_remaining - cps_pkg::IDX_W'(1);
                if (r_remaining == cps_pkg::IDX_W'(1)) begin
                    n_state = cps_pkg::ST_RD_0;
                end else begin
                    n_state = cps_pkg::ST_IDLE;
                end
            end
            cps_pkg::ST_RD_0: begin
                rd_addr = '0;
                n_state = cps_pkg::ST_EMIT_0;
            end
            cps_pkg::ST_EMIT_0: begin
                n_strobe   = 1'b1;
                n_position = '0;
                n_last     = 1'b1;
                n_state    = cps_pkg::ST_IDLE;
            end
            default: begin
                n_state = cps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cps_pkg::ST_IDLE;
            r_remaining <= cps_pkg::IDX_W'(DECK_SIZE - 1);
            r_strobe    <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_strobe    <= n_strobe;
            if (rebuild) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[mem_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data  <= mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
        r_rd_addr  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cps_pkg::ST_DIV && mod_done) begin
            r_j <= mod_rem;
        end
        if (r_state == cps_pkg::ST_RD_J) begin
            r_held <= rd_value;
        end
        r_position <= n_position;
        r_last     <= n_last;
        r_card     <= n_card;
    end

    assign o_strobe     = r_strobe;
    assign o_position   = r_position;
    assign o_card_value = r_card.value;
    assign o_card_suit  = r_card.suit;
    assign o_last       = r_last;

endmodule

[dv/card_permutation_shuffler_top_test.sv]
`timescale 1ns / 1ps

module card_permutation_shuffler_top_test;

    localparam int DECK         = 52;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 640;

    typedef struct packed {
        logic [cps_pkg::IDX_W-1:0]  position;
        logic [cps_pkg::VAL_W-1:0]  value;
        logic [cps_pkg::SUIT_W-1:0] suit;
        logic                       last;
    } t_card_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       start         = 1'b0;
    logic                       i_req_type    = cps_pkg::REQ_BUILD;
    logic [cps_pkg::WORD_W-1:0] i_random_word = '0;
    logic                       busy;
    logic                       o_strobe;
    logic [cps_pkg::IDX_W-1:0]  o_position;
    logic [cps_pkg::VAL_W-1:0]  o_card_value;
    logic [cps_pkg::SUIT_W-1:0] o_card_suit;
    logic                       o_last;

    // Shadow copy of the deck and of the shuffle position.
    logic [cps_pkg::IDX_W-1:0] deck_model [DECK];
    int                        remaining_model;
    t_card_result              expected_cards [$];

    bit idle_on;
    int mismatches;
    int items_taken;
    int steps_ignored;
    int cards_seen;
    int decks_finished;
    int stall_cycles;

    always #2 i_clk = ~i_clk;

    card_permutation_shuffler_top #(
        .DECK_SIZE(DECK)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_random_word(i_random_word),
        .o_strobe     (o_strobe),
        .o_position   (o_position),
        .o_card_value (o_card_value),
        .o_card_suit  (o_card_suit),
        .o_last       (o_last)
    );

    function automatic void order_deck();
        for (int p = 0; p < DECK; p++) begin
            deck_model[p] = cps_pkg::IDX_W'(p);
        end
        remaining_model = DECK - 1;
    endfunction

    function automatic t_card_result card_at(input int pos, input logic is_last);
        t_card_result card;
        int           code;
        code          = int'(deck_model[pos]);
        card.position = cps_pkg::IDX_W'(pos);
        card.value    = cps_pkg::VAL_W'(code % cps_pkg::SUIT_CARDS + 1);
        card.suit     = cps_pkg::SUIT_W'(code / cps_pkg::SUIT_CARDS);
        card.last     = is_last;
        return card;
    endfunction

    // Applies one accepted word to the shadow deck and queues the cards it
    // makes final. Returns 1 when the word is a step that the block drops.
    function automatic bit shuffle_deck_predict(input logic req,
                                                input logic [cps_pkg::WORD_W-1:0] word);
        int                        r;
        int                        j;
        logic [cps_pkg::IDX_W-1:0] held;
        if (req == cps_pkg::REQ_BUILD) begin
            order_deck();
            return 1'b0;
        end
        r = remaining_model;
        if (r == 0) begin
            return 1'b1;
        end
        j             = int'(longint'(word) % longint'(r + 1));
        held          = deck_model[r];
        deck_model[r] = deck_model[j];
        deck_model[j] = held;
        expected_cards.push_back(card_at(r, 1'b0));
        r--;
        remaining_model = r;
        if (r == 0) begin
            expected_cards.push_back(card_at(0, 1'b1));
        end
        return 1'b0;
    endfunction

    function automatic logic [cps_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return cps_pkg::WORD_W'($urandom_range(0, 63));
            default: return cps_pkg::WORD_W'($urandom);
        endcase
    endfunction

    // Offers one word and waits for the block to take it. Start stays high
    // afterwards unless an idle burst follows, so back-to-back words never
    // lower and raise it in the same step.
    task automatic send_word(input logic req, input logic [cps_pkg::WORD_W-1:0] word);
        bit ignored;
        start         <= 1'b1;
        i_req_type    <= req;
        i_random_word <= word;
        do @(posedge i_clk); while (busy);
        ignored = shuffle_deck_predict(req, word);
        if (ignored) begin
            steps_ignored++;
        end else begin
            items_taken++;
        end
        if (idle_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            // Sometimes let the block finish first, so the gap lands while it is idle.
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_step();
        send_word(cps_pkg::REQ_STEP, pick_word());
    endtask

    task automatic send_rebuild();
        send_word(cps_pkg::REQ_BUILD, cps_pkg::WORD_W'($urandom));
    endtask

    task automatic test_word_extremes();
        send_word(cps_pkg::REQ_STEP, '0);
        send_word(cps_pkg::REQ_STEP, '1);
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(32'h2AAA_AAAA));
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(32'h5555_5555));
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(1));
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(46));
        // A rebuild in mid-shuffle throws away the partial deck.
        send_word(cps_pkg::REQ_BUILD, '1);
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(DECK - 1));
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(DECK));
        send_word(cps_pkg::REQ_BUILD, '0);
        send_word(cps_pkg::REQ_BUILD, cps_pkg::WORD_W'(32'h5555_5555));
        send_word(cps_pkg::REQ_STEP, cps_pkg::WORD_W'(32'h2AAA_AAAA));
    endtask

    task automatic test_full_deck();
        send_rebuild();
        for (int s = 0; s < DECK - 1; s++) begin
            send_step();
        end
        // The deck is finished, so these steps must produce nothing.
        repeat (3) send_step();
        send_rebuild();
        repeat (2) send_step();
    endtask

    task automatic test_random_decks();
        int steps;
        while (items_taken < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_rebuild();
            steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DECK - 2) : DECK - 1;
            for (int s = 0; s < steps; s++) begin
                send_step();
            end
            if (steps == DECK - 1 && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) send_step();
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (2) begin
            send_rebuild();
            for (int s = 0; s < DECK - 1; s++) begin
                send_step();
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_card_result want;
        if (i_rst_n && o_strobe) begin
            cards_seen++;
            if (o_last) begin
                decks_finished++;
            end
            if (expected_cards.size() == 0) begin
                $error("card at position %0d arrived with none expected", o_position);
                mismatches++;
            end else begin
                want = expected_cards.pop_front();
                check_field("position", want.position, o_position);
                check_field("card_value", want.value, o_card_value);
                check_field("card_suit", want.suit, o_card_suit);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        idle_on = 1'b1;
        order_deck();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_word_extremes();
        test_full_deck();
        test_random_decks();
        test_back_to_back();
        start <= 1'b0;

        while (expected_cards.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cards.size() != 0) begin
            $error("%0d cards never arrived", expected_cards.size());
            mismatches++;
        end

        $display("Shuffler run: %0d words taken, %0d steps dropped on a finished deck",
                 items_taken, steps_ignored);
        $display("Cards checked: %0d, full decks dealt: %0d, mismatches: %0d",
                 cards_seen, decks_finished, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
